// ===== hdl/rsns_pkg.sv =====
// Shared constants and command/status types of the receive scoreboard.
package rsns_pkg;

   localparam int MAX_PACKETS_DEF = 1024;

   localparam int REG_W    = 11;
   localparam int SEQ_W    = 16;
   localparam int NSEQ_W   = 10;
   localparam int WORD_W   = 32;
   localparam int OFF_W    = 5;
   localparam int RSP_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THRESHOLD = 1'b1;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_NACK    = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic arr_rd;
      logic arr_upd;
      logic nk_idle;
      logic walk_base;
      logic walk_rd;
      logic walk_chk;
      logic walk_oob;
      logic scan_phase;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic nk_skip;
      logic walk_oob;
      logic walk_end;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/rsns_ctrl.sv =====
// Controller state machine of the receive scoreboard.
module rsns_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_kind,
   input  rsns_pkg::sts_type sts,
   output rsns_pkg::cmd_type cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_ARR_RD   = 3'd2;
   localparam logic [2:0] S_ARR_UPD  = 3'd3;
   localparam logic [2:0] S_NK_CHK   = 3'd4;
   localparam logic [2:0] S_WALK_RD  = 3'd5;
   localparam logic [2:0] S_WALK_CHK = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      phase_in   = phase_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_kind == rsns_pkg::REQ_NACK) ? S_NK_CHK : S_ARR_RD;
            end
         end
         S_ARR_RD: begin
            cmd.arr_rd = 1'b1;
            state_in   = S_ARR_UPD;
         end
         S_ARR_UPD: begin
            cmd.arr_upd = 1'b1;
            state_in    = S_OUT;
         end
         S_NK_CHK: begin
            if (sts.nk_skip) begin
               cmd.nk_idle = 1'b1;
               state_in    = S_OUT;
            end else begin
               cmd.walk_base = 1'b1;
               phase_in      = 1'b0;
               state_in      = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            cmd.scan_phase = phase_ff;
            if (sts.walk_oob) begin
               cmd.walk_oob = 1'b1;
               if (phase_ff) begin
                  state_in = S_OUT;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            cmd.scan_phase = phase_ff;
            cmd.walk_chk   = 1'b1;
            if (sts.walk_end && phase_ff) begin
               state_in = S_OUT;
            end else begin
               if (sts.walk_end) begin
                  phase_in = 1'b1;
               end
               state_in = S_WALK_RD;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== hdl/rsns_dp.sv =====
// Datapath of the receive scoreboard: bitmap memory, pointers, counters, encoder.
module rsns_dp #(
   parameter int MAX_PACKETS = rsns_pkg::MAX_PACKETS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rsns_pkg::cmd_type                cmd,
   output rsns_pkg::sts_type                sts,
   input  logic [rsns_pkg::SEQ_W-1:0]       req_seq,
   input  logic                             csr_wr_en,
   input  logic [rsns_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsns_pkg::REG_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rsns_pkg::RSP_W-1:0]       rsp_tdata
);

   localparam int WORD_W = rsns_pkg::WORD_W;
   localparam int OFF_W  = rsns_pkg::OFF_W;
   localparam int SEQ_W  = rsns_pkg::SEQ_W;
   localparam int REG_W  = rsns_pkg::REG_W;
   localparam int NSEQ_W = rsns_pkg::NSEQ_W;
   localparam int WORDS  = (MAX_PACKETS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W  = $clog2(MAX_PACKETS);
   localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
   localparam int PTR_W  = ($clog2(MAX_PACKETS + 1) + 1 > 12) ? $clog2(MAX_PACKETS + 1) + 1 : 12;
   localparam int CMP_W  = (PTR_W > SEQ_W) ? PTR_W : SEQ_W;
   localparam logic [PTR_W-1:0] MAX_P     = PTR_W'(MAX_PACKETS);
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(WORDS - 1);

   logic [WORD_W-1:0] mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [REG_W-1:0]  pc_ff, pc_in, thr_ff, thr_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [PTR_W-1:0]  base_ff, base_in, scan_ff, scan_in, walk_ff, walk_in;
   logic              scan_on_ff, scan_on_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              fresh_ff, fresh_in, nvalid_ff, nvalid_in;
   logic [NSEQ_W-1:0] nseq_ff, nseq_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [rsns_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PTR_W-1:0]  lim, pc_ext, word_start, cand;
   logic [ADDR_W-1:0] seq_addr, walk_addr;
   logic              seq_in_range, fresh, all_eq;
   logic [IDX_W-1:0]  hi_next;
   logic [WORD_W-1:0] zmask;
   logic [OFF_W-1:0]  pos;
   logic              found, cand_oob, hit;

   always_comb begin
      pc_ext       = PTR_W'(pc_ff);
      lim          = (pc_ext < MAX_P) ? pc_ext : MAX_P;
      all_eq       = PTR_W'(total_ff) == pc_ext;
      seq_addr     = seq_ff[ADDR_W+OFF_W-1:OFF_W];
      walk_addr    = walk_ff[ADDR_W+OFF_W-1:OFF_W];
      seq_in_range = CMP_W'(seq_ff) < CMP_W'(lim);
      fresh        = seq_in_range & ~rd_data_ff[seq_ff[OFF_W-1:0]];
      hi_next      = (fresh && (CMP_W'(seq_ff) > CMP_W'(hi_ff))) ? seq_ff[IDX_W-1:0] : hi_ff;

      // first missing bit at or above the walk offset
      zmask = ~rd_data_ff & ({WORD_W{1'b1}} << walk_ff[OFF_W-1:0]);
      found = |zmask;
      pos   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (zmask[i]) begin
            pos = OFF_W'(i);
         end
      end
      word_start = {walk_ff[PTR_W-1:OFF_W], {OFF_W{1'b0}}};
      cand       = found ? (word_start | PTR_W'(pos)) : (word_start + PTR_W'(WORD_W));
      cand_oob   = cand >= lim;
      hit        = found & ~cand_oob;
   end

   assign sts.clear_last = clr_ff == LAST_ROW;
   assign sts.nk_skip    = ~scan_on_ff | all_eq;
   assign sts.walk_oob   = walk_ff >= lim;
   assign sts.walk_end   = found | cand_oob;
   assign sts.out_free   = ~rsp_tvalid_ff | rsp_tready;

   always_comb begin
      mem_we    = cmd.clear_step | (cmd.arr_upd & fresh);
      mem_waddr = cmd.clear_step ? clr_ff : seq_addr;
      mem_wdata = cmd.clear_step ? '0
                : (rd_data_ff | (WORD_W'(1) << seq_ff[OFF_W-1:0]));
      mem_re    = cmd.arr_rd | cmd.walk_rd;
      mem_raddr = cmd.arr_rd ? seq_addr : walk_addr;
   end

   always_comb begin
      clr_in        = cmd.clear_step ? clr_ff + 1'b1 : clr_ff;
      pc_in         = pc_ff;
      thr_in        = thr_ff;
      total_in      = total_ff;
      hi_in         = hi_ff;
      base_in       = base_ff;
      scan_in       = scan_ff;
      walk_in       = walk_ff;
      scan_on_in    = scan_on_ff;
      seq_in        = cmd.load ? req_seq : seq_ff;
      fresh_in      = fresh_ff;
      nvalid_in     = nvalid_ff;
      nseq_in       = nseq_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_index)
            rsns_pkg::CSR_PACKET_COUNT:    pc_in  = csr_wdata;
            rsns_pkg::CSR_START_THRESHOLD: thr_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.arr_upd) begin
         if (fresh) begin
            total_in = total_ff + 1'b1;
         end
         hi_in      = hi_next;
         scan_on_in = scan_on_ff | (CMP_W'(hi_next) >= CMP_W'(thr_ff));
         fresh_in   = fresh;
         nvalid_in  = 1'b0;
         nseq_in    = '0;
      end

      if (cmd.nk_idle) begin
         fresh_in  = 1'b0;
         nvalid_in = 1'b0;
         nseq_in   = '0;
      end

      if (cmd.walk_base) begin
         walk_in = base_ff;
      end

      // pointer already at or past the limit: the walk does not run
      if (cmd.walk_oob) begin
         if (cmd.scan_phase) begin
            scan_in   = base_ff;
            fresh_in  = 1'b0;
            nvalid_in = 1'b0;
            nseq_in   = '0;
         end else begin
            walk_in = scan_ff;
         end
      end

      if (cmd.walk_chk) begin
         if (found || cand_oob) begin
            if (cmd.scan_phase) begin
               fresh_in  = 1'b0;
               nvalid_in = hit;
               nseq_in   = hit ? cand[NSEQ_W-1:0] : '0;
               if (hit && (cand != lim - 1'b1)) begin
                  scan_in = cand + 1'b1;
               end else begin
                  scan_in = base_ff;
               end
            end else begin
               base_in = hit ? cand : lim;
               walk_in = scan_ff;
            end
         end else begin
            walk_in = cand;
         end
      end

      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {2'b00, scan_on_ff, all_eq, nseq_ff, nvalid_ff, fresh_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         pc_ff         <= '0;
         thr_ff        <= '0;
         total_ff      <= '0;
         hi_ff         <= '0;
         base_ff       <= '0;
         scan_ff       <= '0;
         scan_on_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         pc_ff         <= pc_in;
         thr_ff        <= thr_in;
         total_ff      <= total_in;
         hi_ff         <= hi_in;
         base_ff       <= base_in;
         scan_ff       <= scan_in;
         scan_on_ff    <= scan_on_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      seq_ff      <= seq_in;
      fresh_ff    <= fresh_in;
      nvalid_ff   <= nvalid_in;
      nseq_ff     <= nseq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_PACKETS))
      else $error("distinct packet count exceeds bitmap size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_fresh_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.arr_upd && fresh) |=> (total_ff == CNT_W'($past(total_ff) + 1'b1)))
      else $error("fresh arrival did not bump the packet count");

endmodule

// ===== hdl/receive_scoreboard_nack_scan_unit.sv =====
// Top level of the selective-repeat receive scoreboard with nack scan.
//
// Receive scoreboard of a selective-repeat transfer. Each request on the req_ channel is
// either an arrival (req_tuser = 0, sequence number in req_tdata) or a nack request
// (req_tuser = 1). Every request yields exactly one response on rsp_. Arrivals mark the
// sequence number in a bitmap held in a 32-bit-wide memory (one read and one write port,
// registered read), reading the word and then writing it back before the response. A nack
// request first walks the base pointer past received entries, then scans from the scan
// pointer for the first missing number; both walks check one 32-bit memory word at a time
// through a priority encoder, reading a word and then checking it. One request is worked
// on at a time; the next one is accepted once the response has moved into the output
// register, even while that response still waits for rsp_tready. After reset the block
// sweeps all ceil(MAX_PACKETS / 32) words of the bitmap clear, one word per cycle, before
// it accepts the first request; configuration writes are taken at any time and should only
// be issued while no request is in flight.
module receive_scoreboard_nack_scan_unit #(
   parameter int MAX_PACKETS = rsns_pkg::MAX_PACKETS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rsns_pkg::SEQ_W-1:0]       req_tdata,   // [15:0] seq_num
   input  logic                             req_tuser,   // [0] req_type
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] fresh_packet, [1] nack_valid, [11:2] nack_seq, [12] all_received,
   // [13] scan_enabled, [15:14] zero
   output logic [rsns_pkg::RSP_W-1:0]       rsp_tdata,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [rsns_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsns_pkg::REG_W-1:0]       csr_wdata
);

   rsns_pkg::cmd_type cmd;
   rsns_pkg::sts_type sts;

   // sequencing: clear sweep, request decode, walk phases, response handoff
   rsns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // bitmap, pointers, counters, encoder and response register
   rsns_dp #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_seq    (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/rsns_response_checker.sv =====
// Response checker for the receive scoreboard: tracks requests, predicts and compares responses.
`timescale 1ns / 1ps

module rsns_response_checker
   import rsns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [SEQ_W-1:0]     req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output int                   error_count,
   output int                   pending_count
);

   localparam int MAP_DEPTH = MAX_PACKETS_DEF;

   typedef struct packed {
      logic              scan_enabled;
      logic              all_received;
      logic [NSEQ_W-1:0] nack_seq;
      logic              nack_valid;
      logic              fresh_packet;
   } outcome_type;

   // mirror of the scoreboard state
   logic [MAP_DEPTH-1:0] seen_map;
   logic [REG_W-1:0]     count_reg;
   logic [REG_W-1:0]     thresh_reg;
   int unsigned          seen_total;
   int unsigned          top_seq;
   int unsigned          base_ptr;
   int unsigned          scan_ptr;
   logic                 scan_live;

   outcome_type pending_outcomes[$];
   int          mismatches = 0;

   task automatic predict_outcome(input logic kind, input logic [SEQ_W-1:0] seq,
                                  output outcome_type res);
      int unsigned limit;
      int unsigned idx;
      limit = (count_reg < MAP_DEPTH) ? count_reg : MAP_DEPTH;
      res   = '0;
      if (kind == REQ_ARRIVAL) begin
         if (seq < limit && !seen_map[seq]) begin
            seen_map[seq] = 1'b1;
            seen_total++;
            if (seq > top_seq) top_seq = seq;
            res.fresh_packet = 1'b1;
         end
         // enable check runs on every arrival, ignored ones too
         if (top_seq >= thresh_reg) scan_live = 1'b1;
      end else if (scan_live && seen_total != count_reg) begin
         while (base_ptr < limit && seen_map[base_ptr]) base_ptr++;
         idx = scan_ptr;
         while (idx < limit && seen_map[idx]) idx++;
         if (idx < limit) begin
            res.nack_valid = 1'b1;
            res.nack_seq   = NSEQ_W'(idx);
            scan_ptr       = (idx == limit - 1) ? base_ptr : idx + 1;
         end else begin
            scan_ptr = base_ptr;
         end
      end
      res.all_received = (seen_total == count_reg);
      res.scan_enabled = scan_live;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, actual %0d", field, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         seen_map   = '0;
         count_reg  = '0;
         thresh_reg = '0;
         seen_total = 0;
         top_seq    = 0;
         base_ptr   = 0;
         scan_ptr   = 0;
         scan_live  = 1'b0;
         pending_outcomes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PACKET_COUNT:    count_reg  = csr_wdata;
               CSR_START_THRESHOLD: thresh_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $error("response %h with no request outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               got  = outcome_type'(rsp_tdata[13:0]);
               check_field("fresh_packet", want.fresh_packet, got.fresh_packet);
               check_field("nack_valid", want.nack_valid, got.nack_valid);
               check_field("nack_seq", want.nack_seq, got.nack_seq);
               check_field("all_received", want.all_received, got.all_received);
               check_field("scan_enabled", want.scan_enabled, got.scan_enabled);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_outcome(req_tuser, req_tdata, want);
            pending_outcomes.push_back(want);
         end
      end
      pending_count <= pending_outcomes.size();
      error_count   <= mismatches;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives requests and register writes into the receive scoreboard, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
   import rsns_pkg::*;

   localparam int ITEM_TARGET   = 1250;
   localparam int STALL_MAX     = 8;
   // long receiver hold-off so the block backs up into its request port
   localparam int HOLD_CYCLES   = 300;
   // settle time before a register write; every request has a response
   localparam int SETTLE_CYCLES = 8;
   // drain time after the last response, with room past a full nack sweep
   localparam int DRAIN_CYCLES  = 150;
   // worst quiet stretch: hold-off plus a full sweep plus stalls, taken several times
   localparam int QUIET_LIMIT   = 3000;
   localparam int MAP_DEPTH     = MAX_PACKETS_DEF;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SEQ_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = REQ_ARRIVAL;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_PACKET_COUNT;
   logic [REG_W-1:0]     csr_wdata  = '0;

   int error_count;
   int pending_count;
   int items_sent   = 0;
   int quiet_cycles = 0;

   // stimulus pacing: burst_mode is shared by the sender and receiver, hold_rsp drives the receiver
   bit burst_mode = 1'b0;
   bit hold_rsp   = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   receive_scoreboard_nack_scan_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rsns_response_checker i_response_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Offer one request, after a random gap unless in burst mode. Called at a
   // rising edge; returns at the edge where the request is accepted, with
   // tvalid still high so a back-to-back request needs no second assignment.
   task automatic send_request(input logic kind, input logic [SEQ_W-1:0] seq);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seq;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop tvalid and wait until every response has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Raise the write enable for exactly one edge. Wait an edge first so the
   // lowering of a previous write never shares a time step with this raise.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [REG_W-1:0] count, input logic [REG_W-1:0] thresh);
      wait_idle();
      write_reg(CSR_PACKET_COUNT, count);
      write_reg(CSR_START_THRESHOLD, thresh);
   endtask

   // Mostly nacks and in-range arrivals, so the bitmap fills and completes;
   // the rest probes the range edge and arbitrary 16-bit numbers.
   task automatic random_item(input int limit);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         send_request(REQ_NACK, SEQ_W'($urandom));
      else if (pick < 85 && limit > 0)
         send_request(REQ_ARRIVAL, SEQ_W'($urandom_range(0, limit - 1)));
      else if (pick < 95)
         send_request(REQ_ARRIVAL, SEQ_W'(limit + $urandom_range(0, 3)));
      else
         send_request(REQ_ARRIVAL, SEQ_W'($urandom));
   endtask

   // Receiver: stall a random number of cycles per response, none in burst
   // mode, and once hold off for a long stretch to back the block up.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      forever begin
         if (hold_rsp && !held) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(0, STALL_MAX);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [REG_W-1:0] count;
      logic [REG_W-1:0] thresh;
      int               phase_idx;
      int               span;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Full-size transfer with a high threshold so the
      // enable point is reached on a known arrival.
      configure(11'd1024, 11'd1000);
      send_request(REQ_NACK, 16'hFFFF);       // nack before scanning is enabled
      send_request(REQ_ARRIVAL, 16'd3);
      send_request(REQ_ARRIVAL, 16'd3);       // duplicate
      send_request(REQ_ARRIVAL, 16'd1024);    // just past the valid range
      send_request(REQ_ARRIVAL, 16'hFFFF);    // ignored, threshold still checked
      send_request(REQ_ARRIVAL, 16'd0);
      send_request(REQ_ARRIVAL, 16'd1023);    // top of range, enables scanning
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_ARRIVAL, 16'd1022);

      // Shrink the transfer below what is already held: complete at once,
      // then the scan pointer sits past the reduced count.
      configure(11'd4, 11'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_ARRIVAL, 16'd1);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_ARRIVAL, 16'd2);
      send_request(REQ_NACK, 16'd0);

      // Count equals the distinct numbers already held: nacks see all received, then 5 and 4 arrive.
      configure(11'd6, 11'd1024);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_ARRIVAL, 16'd5);
      send_request(REQ_ARRIVAL, 16'd4);

      // Empty transfer.
      configure(11'd0, 11'd0);
      send_request(REQ_NACK, 16'd0);
      send_request(REQ_ARRIVAL, 16'd0);

      // Random phases, each with its own transfer size and threshold. Sizes
      // cycle through small, full-size, empty and mid-range choices in turn.
      phase_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_idx % 8)
            0: count = REG_W'($urandom_range(2, 64));
            1: count = REG_W'(MAP_DEPTH);
            2: count = '0;
            3: count = REG_W'($urandom_range(64, 400));
            4: count = REG_W'(1);
            5: count = REG_W'($urandom_range(2, 32));
            6: count = REG_W'($urandom_range(400, MAP_DEPTH));
            default: count = REG_W'($urandom_range(1, MAP_DEPTH));
         endcase
         case ($urandom_range(0, 2))
            0: thresh = '0;
            1: thresh = REG_W'(MAP_DEPTH);
            default: thresh = REG_W'($urandom_range(0, count));
         endcase
         configure(count, thresh);
         // one phase runs flat out against a stalled receiver
         burst_mode = (phase_idx == 1) || ($urandom_range(0, 3) == 0);
         if (phase_idx == 1) hold_rsp = 1'b1;
         span = $urandom_range(60, 140);
         repeat (span) random_item((count < MAP_DEPTH) ? count : MAP_DEPTH);
         phase_idx++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rsns_pkg.sv
hdl/rsns_ctrl.sv
hdl/rsns_dp.sv
hdl/receive_scoreboard_nack_scan_unit.sv
tb/rsns_response_checker.sv
tb/tb_top.sv
